// File: rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the line stepper
// Command and register codes, line modes and the configuration bundle.
// ----------------------------------------------------------------------------
package bls_pkg;

  // default coordinate width of the line end points
  localparam int COORD_BITS_DEF = 12;

  // fixed widths of the configuration registers
  localparam int ORIGIN_BITS = 12;
  localparam int COLOR_BITS  = 24;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  // command codes
  typedef enum logic [1:0] {
    CMD_DRAW     = 2'd0,
    CMD_SET_PEN  = 2'd1,
    CMD_FROM_PEN = 2'd2,
    CMD_STEP     = 2'd3
  } cmd_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_ORIGIN_X  = 2'd0,
    REG_ORIGIN_Y  = 2'd1,
    REG_DOT_PEN   = 2'd2,
    REG_PEN_COLOR = 2'd3
  } reg_idx_e;

  // walker modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_HSPAN = 3'd1,
    MODE_VSPAN = 3'd2,
    MODE_XMAJ  = 3'd3,
    MODE_YMAJ  = 3'd4
  } line_mode_e;

  // configuration seen by the walker
  typedef struct packed {
    logic [ORIGIN_BITS-1:0] origin_x;
    logic [ORIGIN_BITS-1:0] origin_y;
    logic                   dot_pen;
    logic [COLOR_BITS-1:0]  pen_color;
  } cfg_t;

endpackage

// File: rtl/bls_apb_regs.sv
// ----------------------------------------------------------------------------
// bls_apb_regs: configuration registers
// APB-style register file holding origin, dot pen and pen color.
// ----------------------------------------------------------------------------
module bls_apb_regs import bls_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X:  cfg_d.origin_x  = pwdata[ORIGIN_BITS-1:0];
        REG_ORIGIN_Y:  cfg_d.origin_y  = pwdata[ORIGIN_BITS-1:0];
        REG_DOT_PEN:   cfg_d.dot_pen   = pwdata[0];
        REG_PEN_COLOR: cfg_d.pen_color = pwdata[COLOR_BITS-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:  prdata = {{(APB_DATA_BITS-ORIGIN_BITS){1'b0}}, cfg_q.origin_x};
      REG_ORIGIN_Y:  prdata = {{(APB_DATA_BITS-ORIGIN_BITS){1'b0}}, cfg_q.origin_y};
      REG_DOT_PEN:   prdata = {{(APB_DATA_BITS-1){1'b0}}, cfg_q.dot_pen};
      REG_PEN_COLOR: prdata = {{(APB_DATA_BITS-COLOR_BITS){1'b0}}, cfg_q.pen_color};
      default:       prdata = '0;
    endcase
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/bls_line_setup.sv
// ----------------------------------------------------------------------------
// bls_line_setup: line classification
// Works out mode, start of walk, deltas and initial remainder of a new line.
// ----------------------------------------------------------------------------
module bls_line_setup import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  output line_mode_e                   mode_o,
  output logic signed [COORD_BITS-1:0] walk_x_o,
  output logic signed [COORD_BITS-1:0] walk_y_o,
  output logic [COORD_BITS:0]          delta_x_o,
  output logic [COORD_BITS:0]          delta_y_o,
  output logic [COORD_BITS+1:0]        error_o
);

  logic [COORD_BITS:0] diff_x, diff_y;

  // absolute deltas
  assign diff_x    = {x1_i[COORD_BITS-1], x1_i} - {x0_i[COORD_BITS-1], x0_i};
  assign diff_y    = {y1_i[COORD_BITS-1], y1_i} - {y0_i[COORD_BITS-1], y0_i};
  assign delta_x_o = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
  assign delta_y_o = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

  // spans start at the lower end, other lines at the start point
  always_comb begin
    walk_x_o = x0_i;
    walk_y_o = y0_i;
    error_o  = '0;
    if (y0_i == y1_i) begin
      mode_o   = MODE_HSPAN;
      walk_x_o = (x0_i < x1_i) ? x0_i : x1_i;
    end else if (x0_i == x1_i) begin
      mode_o   = MODE_VSPAN;
      walk_y_o = (y0_i < y1_i) ? y0_i : y1_i;
    end else if (delta_x_o >= delta_y_o) begin
      mode_o  = MODE_XMAJ;
      error_o = {2'b00, delta_x_o[COORD_BITS:1]};
    end else begin
      mode_o  = MODE_YMAJ;
      error_o = {2'b00, delta_y_o[COORD_BITS:1]};
    end
  end

endmodule

// File: rtl/bls_step_core.sv
// ----------------------------------------------------------------------------
// bls_step_core: command handling and pixel walker
// Holds pen and line state, steps one pixel per item, registers the result.
// ----------------------------------------------------------------------------
module bls_step_core import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         plot_o,
  output logic                         last_o
);

  localparam int SumBits = ((COORD_BITS > ORIGIN_BITS) ? COORD_BITS : ORIGIN_BITS) + 2;

  // line and pen state
  line_mode_e                   mode_q, mode_d;
  logic signed [COORD_BITS-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic signed [COORD_BITS-1:0] walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS:0]          dx_q, dx_d, dy_q, dy_d;
  logic [COORD_BITS+1:0]        err_q, err_d;
  logic [COORD_BITS:0]          span_q, span_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS:0]   pixel_x_q, pixel_y_q;
  logic [COLOR_BITS-1:0]        color_q;
  logic                         plot_q, last_q;

  // setup unit
  logic signed [COORD_BITS-1:0] x0, y0;
  line_mode_e                   su_mode;
  logic signed [COORD_BITS-1:0] su_walk_x, su_walk_y;
  logic [COORD_BITS:0]          su_dx, su_dy;
  logic [COORD_BITS+1:0]        su_err;

  // step datapath
  logic                         in_fire, emit, plot_d, last_d;
  logic [COORD_BITS:0]          span_len, span_add_x, span_add_y;
  logic [COORD_BITS:0]          rel_x, rel_y;
  logic [COORD_BITS+1:0]        err_sum, major, minor;
  logic [COORD_BITS-1:0]        step_x, step_y;
  logic [SumBits-1:0]           sum_x, sum_y;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign x0 = (cmd_i == CMD_FROM_PEN) ? pen_x_q : start_x_i;
  assign y0 = (cmd_i == CMD_FROM_PEN) ? pen_y_q : start_y_i;

  bls_line_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .x0_i      (x0),
    .y0_i      (y0),
    .x1_i      (end_x_i),
    .y1_i      (end_y_i),
    .mode_o    (su_mode),
    .walk_x_o  (su_walk_x),
    .walk_y_o  (su_walk_y),
    .delta_x_o (su_dx),
    .delta_y_o (su_dy),
    .error_o   (su_err)
  );

  // unit steps toward the target, +1 or -1
  assign step_x = {{(COORD_BITS-1){!(tgt_x_q > walk_x_q)}}, 1'b1};
  assign step_y = {{(COORD_BITS-1){!(tgt_y_q > walk_y_q)}}, 1'b1};

  // remainder update operands for the two diagonal modes
  assign major   = (mode_q == MODE_XMAJ) ? {1'b0, dx_q} : {1'b0, dy_q};
  assign minor   = (mode_q == MODE_XMAJ) ? {1'b0, dy_q} : {1'b0, dx_q};
  assign err_sum = err_q + minor;

  // span offsets
  assign span_len   = (mode_q == MODE_HSPAN) ? dx_q : dy_q;
  assign span_add_x = (mode_q == MODE_HSPAN) ? span_q : '0;
  assign span_add_y = (mode_q == MODE_VSPAN) ? span_q : '0;

  // command decode and walker next state
  always_comb begin
    mode_d   = mode_q;
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    err_d    = err_q;
    span_d   = span_q;
    emit     = 1'b0;
    plot_d   = 1'b1;
    last_d   = 1'b0;
    rel_x    = {walk_x_q[COORD_BITS-1], walk_x_q};
    rel_y    = {walk_y_q[COORD_BITS-1], walk_y_q};
    if (in_fire) begin
      case (cmd_i)
        CMD_DRAW, CMD_FROM_PEN: begin
          mode_d   = su_mode;
          walk_x_d = su_walk_x;
          walk_y_d = su_walk_y;
          tgt_x_d  = end_x_i;
          tgt_y_d  = end_y_i;
          dx_d     = su_dx;
          dy_d     = su_dy;
          err_d    = su_err;
          span_d   = '0;
        end
        CMD_SET_PEN: begin
          pen_x_d = end_x_i;
          pen_y_d = end_y_i;
        end
        default: begin
          unique case (mode_q)
            MODE_HSPAN, MODE_VSPAN: begin
              emit   = 1'b1;
              rel_x  = {walk_x_q[COORD_BITS-1], walk_x_q} + span_add_x;
              rel_y  = {walk_y_q[COORD_BITS-1], walk_y_q} + span_add_y;
              plot_d = !(cfg_i.dot_pen && span_q[0]);
              last_d = span_q >= span_len;
              span_d = span_q + 1'b1;
            end
            MODE_XMAJ: begin
              emit     = 1'b1;
              walk_x_d = walk_x_q + step_x;
              if (err_sum >= major) begin
                err_d    = err_sum - major;
                walk_y_d = walk_y_q + step_y;
              end else begin
                err_d = err_sum;
              end
              last_d = walk_x_d == tgt_x_q;
            end
            MODE_YMAJ: begin
              emit     = 1'b1;
              walk_y_d = walk_y_q + step_y;
              if (err_sum >= major) begin
                err_d    = err_sum - major;
                walk_x_d = walk_x_q + step_x;
              end else begin
                err_d = err_sum;
              end
              last_d = walk_y_d == tgt_y_q;
            end
            default: emit = 1'b0;
          endcase
          if (mode_q == MODE_XMAJ || mode_q == MODE_YMAJ) begin
            rel_x  = {walk_x_d[COORD_BITS-1], walk_x_d};
            rel_y  = {walk_y_d[COORD_BITS-1], walk_y_d};
            plot_d = !(cfg_i.dot_pen && walk_x_d[0]);
          end
          if (emit && last_d) begin
            mode_d = MODE_IDLE;
          end
        end
      endcase
    end
  end

  // origin offset, wrapped to the output width
  assign sum_x = {{(SumBits-COORD_BITS-1){rel_x[COORD_BITS]}}, rel_x}
               + {{(SumBits-ORIGIN_BITS){cfg_i.origin_x[ORIGIN_BITS-1]}}, cfg_i.origin_x};
  assign sum_y = {{(SumBits-COORD_BITS-1){rel_y[COORD_BITS]}}, rel_y}
               + {{(SumBits-ORIGIN_BITS){cfg_i.origin_y[ORIGIN_BITS-1]}}, cfg_i.origin_y};

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      err_q       <= '0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      walk_x_q    <= walk_x_d;
      walk_y_q    <= walk_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      err_q       <= err_d;
      span_q      <= span_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      pixel_x_q <= sum_x[COORD_BITS:0];
      pixel_y_q <= sum_y[COORD_BITS:0];
      color_q   <= cfg_i.pen_color;
      plot_q    <= plot_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = color_q;
  assign plot_o        = plot_q;
  assign last_o        = last_q;

`ifndef ASSERT_OFF
  // a step with no line loaded leaves the result slot empty once drained
  a_idle_step_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == CMD_STEP && mode_q == MODE_IDLE) |=> !out_valid_q)
    else $error("step while idle produced a result");

  // the final pixel of a line returns the walker to idle
  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd_i == CMD_STEP && emit && last_d) |=> mode_q == MODE_IDLE)
    else $error("walker still active after last pixel");

  // span walk never passes the far end
  a_span_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HSPAN || mode_q == MODE_VSPAN) |-> span_q <= span_len)
    else $error("span index beyond span length");

  // remainder stays below the major delta on diagonal lines
  a_err_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_XMAJ || mode_q == MODE_YMAJ) |-> err_q < major)
    else $error("remainder not below major delta");
`endif

endmodule

// File: rtl/bresenham_line_stepper_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit: line rasterizer top level
// Line commands come in on the input channel, pixels leave on the output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command item: draw a
//   line, set the pen, draw from the pen, or step. Only a step on a loaded
//   line yields an output item (pixel position with origin added, color,
//   plot and last flags); all other items are absorbed silently.
//   Result: a result is registered and visible in the cycle after its step item is accepted.
//   Throughput: one item per cycle while in_ready_o is high; the walker state update
//   (one add and compare on the remainder plus the origin add) is combinational.
//   Stall: the output register holds a waiting pixel; in_ready_o stays high
//   while the slot is empty or being drained, and drops while a pixel waits
//   and out_ready_i is low, so nothing is lost or repeated.
//   Reset: all line and pen state clears, the walker goes idle, the state and
//   configuration registers return to zero and no output is pending.
//   Configuration: APB writes to origin_x (0x0), origin_y (0x4), dot_pen
//   (0x8) and pen_color (0xC) take effect on the following step.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit import bls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o,
  output logic [COLOR_BITS-1:0]        pixel_color_o,
  output logic                         plot_o,
  output logic                         last_o
);

  cfg_t cfg;

  // configuration registers
  bls_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // walker and result register
  bls_step_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .plot_o        (plot_o),
    .last_o        (last_o)
  );

endmodule
